FILE: rtl/bfk_pkg.sv
// bfk_pkg: shared types and constants of the bone chain forward kinematics core
// no dependencies
`timescale 1ns / 1ps
package bfk_pkg;
    localparam int unsigned CORDIC_STEPS = 16;
    localparam logic signed [33:0] CORDIC_START = 34'sd652032874;

    localparam logic [1:0] CFG_FACING_LEFT = 2'd0;
    localparam logic [1:0] CFG_ROOT_POS_X  = 2'd1;
    localparam logic [1:0] CFG_ROOT_POS_Y  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_CORDIC,
        ST_MUL,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [15:0] ang;
    } t_pose;

    function automatic logic signed [33:0] atan_step(input logic [3:0] i);
        logic signed [33:0] v;
        case (i)
            4'd0:  v = 34'sd536870912;
            4'd1:  v = 34'sd316933406;
            4'd2:  v = 34'sd167458907;
            4'd3:  v = 34'sd85004756;
            4'd4:  v = 34'sd42667331;
            4'd5:  v = 34'sd21354465;
            4'd6:  v = 34'sd10679838;
            4'd7:  v = 34'sd5340245;
            4'd8:  v = 34'sd2670163;
            4'd9:  v = 34'sd1335087;
            4'd10: v = 34'sd667544;
            4'd11: v = 34'sd333772;
            4'd12: v = 34'sd166886;
            4'd13: v = 34'sd83443;
            4'd14: v = 34'sd41722;
            4'd15: v = 34'sd20861;
            default: v = 34'sd0;
        endcase
        return v;
    endfunction
endpackage

FILE: rtl/bfk_bone_if.sv
// bfk_bone_if, bfk_pose_if: valid/ready channels for bone items and pose results
// no dependencies
`timescale 1ns / 1ps
interface bfk_bone_if;
    logic               valid;
    logic               ready;
    logic [4:0]         bone_id;
    logic [4:0]         parent_id;
    logic               is_root;
    logic signed [31:0] attach_x;
    logic signed [31:0] attach_y;
    logic [15:0]        rest_angle;
    logic [15:0]        pose_angle;
    modport source (output valid, bone_id, parent_id, is_root, attach_x, attach_y,
                    rest_angle, pose_angle, input ready);
    modport sink (input valid, bone_id, parent_id, is_root, attach_x, attach_y,
                  rest_angle, pose_angle, output ready);
endinterface

interface bfk_pose_if;
    logic               valid;
    logic               ready;
    logic [4:0]         out_bone_id;
    logic signed [31:0] world_x;
    logic signed [31:0] world_y;
    logic [15:0]        world_angle;
    modport source (output valid, out_bone_id, world_x, world_y, world_angle, input ready);
    modport sink (input valid, out_bone_id, world_x, world_y, world_angle, output ready);
endinterface

FILE: rtl/bfk_cordic.sv
// bfk_cordic: iterative sine/cosine of a binary angle, q1.30 results
// depends on bfk_pkg
`timescale 1ns / 1ps
module bfk_cordic import bfk_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [15:0]        i_angle,
    output logic               o_done,
    output logic signed [31:0] o_cos,
    output logic signed [31:0] o_sin
);
    logic signed [33:0] r_x, r_y, r_z;
    logic [1:0]         r_q;
    logic [3:0]         r_step;
    logic               r_busy, r_fin, r_done;
    logic signed [31:0] r_cos, r_sin;

    logic [15:0]        w_t;
    logic signed [14:0] w_r;
    logic signed [33:0] w_dx, w_dy;

    assign w_t  = i_angle + 16'h2000;
    assign w_r  = $signed({1'b0, w_t[13:0]}) - 15'sd8192;
    assign w_dx = r_y >>> r_step;
    assign w_dy = r_x >>> r_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= r_fin;
            r_fin  <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 4'd1;
                if (r_step == 4'(CORDIC_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x <= CORDIC_START;
            r_y <= '0;
            r_z <= {{3{w_r[14]}}, w_r, 16'b0};
            r_q <= w_t[15:14];
        end else if (r_busy) begin
            if (!r_z[33]) begin
                r_x <= r_x - w_dx;
                r_y <= r_y + w_dy;
                r_z <= r_z - atan_step(r_step);
            end else begin
                r_x <= r_x + w_dx;
                r_y <= r_y - w_dy;
                r_z <= r_z + atan_step(r_step);
            end
        end
        if (r_fin) begin
            case (r_q)
                2'd0: begin r_cos <= r_x[31:0];    r_sin <= r_y[31:0];    end
                2'd1: begin r_cos <= -r_y[31:0];   r_sin <= r_x[31:0];    end
                2'd2: begin r_cos <= -r_x[31:0];   r_sin <= -r_y[31:0];   end
                default: begin r_cos <= r_y[31:0]; r_sin <= -r_x[31:0];   end
            endcase
        end
    end

    assign o_done = r_done;
    assign o_cos  = r_cos;
    assign o_sin  = r_sin;

    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_fin |=> r_done)
        else $error("cordic finish not followed by done");
    assert property (@(posedge i_clk) disable iff (!i_rst_n) i_start |=> r_busy)
        else $error("cordic did not start");
    assert property (@(posedge i_clk) disable iff (!i_rst_n) !(r_busy && r_fin))
        else $error("cordic busy and finishing at once");
endmodule

FILE: rtl/bone_chain_forward_kinematics_core.sv
// bone_chain_forward_kinematics_core: top level, pose memory, sequencer, multiply
// depends on bfk_pkg, bfk_bone_if, bfk_pose_if, bfk_cordic
`timescale 1ns / 1ps
// Takes one bone per transaction (parents before children) and returns its world
// pose, storing it in an on-chip pose memory of MAX_BONES entries for later
// children. A bone is taken only while the core is idle. A root bone goes through
// the memory read and the write-back only; a child takes one memory read, 16 CORDIC
// iterations with setup and quadrant rotation, the products on one shared 32x32
// multiplier, and the write-back. A finished result waits in the output register
// while the next bone is taken. No clearing pass after reset.
module bone_chain_forward_kinematics_core import bfk_pkg::*; #(
    parameter int unsigned MAX_BONES = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bfk_bone_if.sink    i_bone,
    bfk_pose_if.source  o_pose,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data
);
    localparam int unsigned AW = $clog2(MAX_BONES);

    t_pose  r_mem [MAX_BONES];
    t_pose  r_rd;
    t_state r_state, n_state;

    logic               r_facing;
    logic [31:0]        r_root_x, r_root_y;
    logic [4:0]         r_id;
    logic [AW-1:0]      r_slot;
    logic               r_root;
    logic signed [31:0] r_ax, r_ay;
    logic [15:0]        r_loc;
    logic [2:0]         r_mstep;
    logic signed [63:0] r_prod, r_acc_x, r_acc_y;
    logic               r_out_valid;
    logic [4:0]         r_out_id;
    t_pose              r_out;

    logic [AW-1:0]      w_mod [32];
    logic               w_acc, w_load, w_cstart, w_cdone;
    logic signed [31:0] w_cos, w_sin, w_ma, w_mb;
    logic [15:0]        w_loc;
    logic signed [63:0] w_rnd_x, w_rnd_y;
    t_pose              w_res;

    for (genvar g = 0; g < 32; g++) begin : g_mod
        assign w_mod[g] = AW'(g % MAX_BONES);
    end

    bfk_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_cstart),
        .i_angle (r_rd.ang),
        .o_done  (w_cdone),
        .o_cos   (w_cos),
        .o_sin   (w_sin)
    );

    assign w_acc = i_bone.valid && i_bone.ready;
    assign w_loc = i_bone.rest_angle + i_bone.pose_angle;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:   if (w_acc) n_state = ST_READ;
            ST_READ:   n_state = r_root ? ST_DONE : ST_CORDIC;
            ST_CORDIC: if (w_cdone) n_state = ST_MUL;
            ST_MUL:    if (r_mstep == 3'd4) n_state = ST_DONE;
            ST_DONE:   if (w_load) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        i_bone.ready = (r_state == ST_IDLE);
        w_cstart     = (r_state == ST_READ) && !r_root;
        w_load       = (r_state == ST_DONE) && (!r_out_valid || o_pose.ready);
    end

    assign w_ma    = r_mstep[0] ? r_ay : r_ax;
    assign w_mb    = (r_mstep[0] ^ r_mstep[1]) ? w_sin : w_cos;
    assign w_rnd_x = r_acc_x + 64'sd536870912;
    assign w_rnd_y = r_acc_y + 64'sd536870912;

    always_comb begin
        if (r_root) begin
            w_res.x   = r_root_x + r_ax;
            w_res.y   = r_root_y + r_ay;
            w_res.ang = r_loc;
        end else begin
            w_res.x   = r_rd.x + w_rnd_x[61:30];
            w_res.y   = r_rd.y + w_rnd_y[61:30];
            w_res.ang = r_rd.ang + r_loc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_facing    <= 1'b0;
            r_root_x    <= '0;
            r_root_y    <= '0;
            r_out_valid <= 1'b0;
            r_mstep     <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_FACING_LEFT: r_facing <= i_cfg_data[0];
                    CFG_ROOT_POS_X:  r_root_x <= i_cfg_data;
                    CFG_ROOT_POS_Y:  r_root_y <= i_cfg_data;
                    default: ;
                endcase
            end
            if (w_load) r_out_valid <= 1'b1;
            else if (o_pose.ready) r_out_valid <= 1'b0;
            if (r_state == ST_MUL) r_mstep <= r_mstep + 3'd1;
            else r_mstep <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_rd   <= r_mem[w_mod[i_bone.parent_id]];
            r_id   <= i_bone.bone_id;
            r_slot <= w_mod[i_bone.bone_id];
            r_root <= i_bone.is_root;
            r_ay   <= i_bone.attach_y;
            r_ax   <= r_facing ? -i_bone.attach_x : i_bone.attach_x;
            r_loc  <= r_facing ? -w_loc : w_loc;
        end
        if (w_load) begin
            r_mem[r_slot] <= w_res;
            r_out         <= w_res;
            r_out_id      <= r_id;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_MUL) begin
            r_prod <= w_ma * w_mb;
            case (r_mstep)
                3'd1:    r_acc_x <= r_prod;
                3'd2:    r_acc_x <= r_acc_x - r_prod;
                3'd3:    r_acc_y <= r_prod;
                3'd4:    r_acc_y <= r_acc_y + r_prod;
                default: ;
            endcase
        end
    end

    assign o_pose.valid       = r_out_valid;
    assign o_pose.out_bone_id = r_out_id;
    assign o_pose.world_x     = r_out.x;
    assign o_pose.world_y     = r_out.y;
    assign o_pose.world_angle = r_out.ang;

    assert property (@(posedge i_clk) disable iff (!i_rst_n) w_acc |=> r_state == ST_READ)
        else $error("accepted bone did not start a memory read");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cdone |-> r_state == ST_CORDIC)
        else $error("cordic done outside cordic wait");
    assert property (@(posedge i_clk) disable iff (!i_rst_n) w_load |=> r_out_valid)
        else $error("result not presented after write-back");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MUL) |-> !r_root)
        else $error("root bone in multiply phase");
endmodule

FILE: test/bone_chain_forward_kinematics_core_tb.sv
// testbench for bone_chain_forward_kinematics_core: drives bone transactions in parent
// order, predicts world poses with its own cordic and checks every pose result
// depends on bfk_pkg, bfk_bone_if, bfk_pose_if and the core
`timescale 1ns / 1ps
module bone_chain_forward_kinematics_core_tb;
    import bfk_pkg::*;

    localparam logic [1:0] CFG_SPARE = 2'd3;
    localparam int CYCLE_LIMIT = 600000;
    localparam int PHASE_ITEMS = 200;

    typedef struct {
        bit [4:0]  id;
        bit [31:0] x;
        bit [31:0] y;
        bit [15:0] ang;
    } pose_t;

    class pose_tracker;
        bit        facing;
        bit [31:0] root_x;
        bit [31:0] root_y;
        bit [31:0] px[32];
        bit [31:0] py[32];
        bit [15:0] pang[32];
        bit        written[32];
        pose_t     pending[$];
        longint    atan_lut[16] = '{536870912, 316933406, 167458907, 85004756, 42667331,
            21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
            83443, 41722, 20861};

        function void set_reg(bit [1:0] idx, bit [31:0] d);
            case (idx)
                CFG_FACING_LEFT: facing = d[0];
                CFG_ROOT_POS_X:  root_x = d;
                CFG_ROOT_POS_Y:  root_y = d;
                default: ;
            endcase
        endfunction

        function void sincos(bit [15:0] a, output longint c, output longint s);
            bit [15:0] t;
            longint x, y, z, dx, dy;
            t = a + 16'h2000;
            z = (longint'(t[13:0]) - 8192) * 65536;
            x = 652032874;
            y = 0;
            for (int i = 0; i < 16; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0) begin
                    x -= dx; y += dy; z -= atan_lut[i];
                end else begin
                    x += dx; y -= dy; z += atan_lut[i];
                end
            end
            case (t[15:14])
                2'd0: begin c = x;  s = y;  end
                2'd1: begin c = -y; s = x;  end
                2'd2: begin c = -x; s = -y; end
                default: begin c = y; s = -x; end
            endcase
        endfunction

        function void note_bone(bit [4:0] id, bit [4:0] pid, bit root, bit [31:0] ax,
                                bit [31:0] ay, bit [15:0] ra, bit [15:0] pa);
            bit [15:0] loc;
            longint c, s, sx, sy, rx, ry;
            pose_t r;
            loc = ra + pa;
            if (facing) begin
                loc = -loc;
                ax = -ax;
            end
            r.id = id;
            if (root) begin
                r.x = root_x + ax;
                r.y = root_y + ay;
                r.ang = loc;
            end else begin
                sincos(pang[pid], c, s);
                sx = longint'(signed'(ax));
                sy = longint'(signed'(ay));
                rx = (sx * c - sy * s + (64'sd1 <<< 29)) >>> 30;
                ry = (sx * s + sy * c + (64'sd1 <<< 29)) >>> 30;
                r.x = px[pid] + rx[31:0];
                r.y = py[pid] + ry[31:0];
                r.ang = pang[pid] + loc;
            end
            px[id] = r.x;
            py[id] = r.y;
            pang[id] = r.ang;
            written[id] = 1;
            pending.push_back(r);
        endfunction

        function bit check(pose_t got, output string why);
            pose_t e;
            why = "";
            if (pending.size() == 0) begin
                why = $sformatf("unexpected pose for bone %0d", got.id);
                return 1;
            end
            e = pending.pop_front();
            if (got.id != e.id)
                why = {why, $sformatf(" id %0d/%0d", got.id, e.id)};
            if (got.x != e.x)
                why = {why, $sformatf(" x %h/%h", got.x, e.x)};
            if (got.y != e.y)
                why = {why, $sformatf(" y %h/%h", got.y, e.y)};
            if (got.ang != e.ang)
                why = {why, $sformatf(" ang %h/%h", got.ang, e.ang)};
            return why != "";
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [31:0] i_cfg_data;
    bfk_bone_if  bone();
    bfk_pose_if  pose();

    pose_tracker sb = new();
    int errors = 0;
    int cycles = 0;
    bit quiet = 0;

    bone_chain_forward_kinematics_core uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_bone(bone), .o_pose(pose),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("[bone_chain_forward_kinematics_core] ERROR");
            $finish;
        end
    end

    task automatic report(string why);
        errors++;
        $display("mismatch at cycle %0d:%s", cycles, why);
    endtask

    function automatic int draw_gap();
        return quiet ? 0 : $urandom_range(0, 15);
    endfunction

    // result side: random stalls, checks each accepted transaction
    initial begin
        pose_t got;
        string why;
        int n;
        pose.ready <= 0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            n = draw_gap();
            if (n > 0) begin
                pose.ready <= 0;
                repeat (n) @(posedge i_clk);
            end
            pose.ready <= 1;
            do @(posedge i_clk); while (!pose.valid);
            got.id = pose.out_bone_id;
            got.x = pose.world_x;
            got.y = pose.world_y;
            got.ang = pose.world_angle;
            if (sb.check(got, why))
                report(why);
        end
    end

    task automatic send_bone(bit [4:0] id, bit [4:0] pid, bit root, bit [31:0] ax,
                             bit [31:0] ay, bit [15:0] ra, bit [15:0] pa);
        int n;
        n = draw_gap();
        if (n > 0) begin
            bone.valid <= 0;
            repeat (n) @(posedge i_clk);
        end
        bone.valid <= 1;
        bone.bone_id <= id;
        bone.parent_id <= pid;
        bone.is_root <= root;
        bone.attach_x <= ax;
        bone.attach_y <= ay;
        bone.rest_angle <= ra;
        bone.pose_angle <= pa;
        do @(posedge i_clk); while (!bone.ready);
        sb.note_bone(id, pid, root, ax, ay, ra, pa);
    endtask

    task automatic settle();
        bone.valid <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic cfg_write(bit [1:0] idx, bit [31:0] d);
        i_cfg_we <= 1;
        i_cfg_idx <= idx;
        i_cfg_data <= d;
        @(posedge i_clk);
        i_cfg_we <= 0;
        sb.set_reg(idx, d);
        @(posedge i_clk);
    endtask

    function automatic bit [31:0] pick_offset();
        case ($urandom_range(0, 4))
            0: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
            1, 2: return {{12{$urandom_range(0, 1) == 1}}, 20'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    function automatic bit [15:0] pick_angle();
        case ($urandom_range(0, 5))
            0: return 16'hffff;
            1: return {2'($urandom_range(0, 3)), 14'h2000};
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_bone();
        bit [4:0] id, pid;
        bit root;
        id = 5'($urandom);
        pid = 5'($urandom);
        root = 0;
        if ($urandom_range(0, 3) == 0) begin
            root = 1;
        end else begin
            while (!sb.written[pid]) pid = 5'($urandom);
        end
        send_bone(id, pid, root, pick_offset(), pick_offset(), pick_angle(), pick_angle());
    endtask

    initial begin
        bit [31:0] rx_set[5] = '{32'h0, 32'h8000_0000, 32'h7fff_ffff, 32'h0001_0000, 32'h0};
        bit [31:0] ry_set[5] = '{32'h0, 32'h7fff_ffff, 32'h8000_0000, 32'hfff0_0000, 32'h0};
        i_rst_n <= 0;
        i_cfg_we <= 0;
        i_cfg_idx <= CFG_FACING_LEFT;
        i_cfg_data <= 0;
        bone.valid <= 0;
        bone.bone_id <= 0;
        bone.parent_id <= 0;
        bone.is_root <= 0;
        bone.attach_x <= 0;
        bone.attach_y <= 0;
        bone.rest_angle <= 0;
        bone.pose_angle <= 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: roots, quadrant edges, self parent, extreme offsets
        send_bone(0, 7, 1, 0, 0, 0, 0);
        send_bone(31, 0, 1, 32'h7fff_ffff, 32'h8000_0000, 16'hffff, 16'hffff);
        send_bone(1, 0, 0, 32'h0001_0000, 32'h0, 16'h2000, 0);
        send_bone(2, 1, 0, 32'h0001_0000, 32'h0002_0000, 16'h4000, 16'h2000);
        send_bone(3, 2, 0, 32'h8000_0000, 32'h7fff_ffff, 16'h6000, 0);
        send_bone(4, 3, 0, 32'hffff_ffff, 32'h8000_0000, 16'he000, 16'h1fff);
        send_bone(5, 4, 0, 32'h7fff_ffff, 32'h7fff_ffff, 16'h1fff, 16'h0001);
        send_bone(5, 5, 0, 32'h0003_0000, 32'hfffd_0000, 16'h8000, 0);
        send_bone(31, 31, 0, 32'h8000_0000, 32'h8000_0000, 0, 16'hffff);
        send_bone(6, 31, 0, 32'h1234_5678, 32'h0, 16'hc000, 16'h4000);
        settle();
        quiet = 1;
        cfg_write(CFG_FACING_LEFT, 1);
        cfg_write(CFG_ROOT_POS_X, 32'h8000_0000);
        cfg_write(CFG_ROOT_POS_Y, 32'h7fff_ffff);
        cfg_write(CFG_SPARE, 32'hffff_ffff);
        send_bone(7, 0, 1, 32'h8000_0000, 32'h0, 16'h0001, 0);
        send_bone(8, 7, 0, 32'h8000_0000, 32'h0001_0000, 16'h4000, 16'h4000);
        send_bone(9, 8, 0, 32'h0001_0000, 32'h0, 16'hffff, 0);
        send_bone(9, 9, 0, 32'h7fff_ffff, 32'h8000_0000, 16'h2000, 16'h2000);
        send_bone(10, 0, 1, 32'h7fff_ffff, 32'h8000_0000, 16'hffff, 16'hffff);
        settle();

        for (int ph = 0; ph < 5; ph++) begin
            quiet = ($urandom_range(0, 2) == 0);
            cfg_write(CFG_FACING_LEFT, 32'(ph % 2));
            cfg_write(CFG_ROOT_POS_X, ph == 4 ? 32'($urandom) : rx_set[ph]);
            cfg_write(CFG_ROOT_POS_Y, ph == 4 ? 32'($urandom) : ry_set[ph]);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (k % 50 == 25)
                    quiet = ~quiet;
                random_bone();
            end
            settle();
        end

        if (errors == 0)
            $display("[bone_chain_forward_kinematics_core] OK");
        else
            $display("[bone_chain_forward_kinematics_core] ERROR");
        $finish;
    end
endmodule
